/* src/native_name_escape_encoder_assert.svh */
// Assertion macros for the name escape encoder.
`ifndef NATIVE_NAME_ESCAPE_ENCODER_ASSERT_SVH
`define NATIVE_NAME_ESCAPE_ENCODER_ASSERT_SVH

`ifndef SYNTH
// Plain check, disabled while reset is asserted.
`define NNEE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Cause in one cycle, effect in the next.
`define NNEE_ASSERT_NEXT(name, clk, rst_n, cause, effect, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define NNEE_ASSERT(name, clk, rst_n, prop, msg)
`define NNEE_ASSERT_NEXT(name, clk, rst_n, cause, effect, msg)
`endif

`endif

/* src/nnee_pkg.sv */
package nnee_pkg;

  localparam logic [6:0] CharNul        = 7'h00;
  localparam logic [6:0] CharUnderscore = 7'h5f;
  localparam logic [6:0] CharZero       = 7'h30;
  localparam logic [6:0] CharOne        = 7'h31;
  localparam logic [6:0] CharTwo        = 7'h32;
  localparam logic [6:0] CharThree      = 7'h33;

  localparam logic [15:0] UnitSlash      = 16'h002f;
  localparam logic [15:0] UnitUnderscore = 16'h005f;
  localparam logic [15:0] UnitSemicolon  = 16'h003b;
  localparam logic [15:0] UnitBracket    = 16'h005b;
  localparam logic [15:0] UnitDigitZero  = 16'h0030;
  localparam logic [15:0] UnitDigitThree = 16'h0033;

  localparam logic [7:0] AsciiLimit = 8'h80;

  // Escape lengths in characters.
  localparam logic [2:0] LenShort = 3'd1;
  localparam logic [2:0] LenPair  = 3'd2;
  localparam logic [2:0] LenHex   = 3'd6;

  // One decoded unit waiting for the serializer.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        err;       // segment rejected: emit the error word
    logic        seg_end;   // unit came from the closing byte
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic is_alnum(input logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h005a) ||
           (u >= 16'h0061 && u <= 16'h007a);
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h57 + {3'b000, n});
  endfunction

endpackage

/* src/nnee_if.sv */
interface nnee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       segment_start;
  logic       segment_end;

  modport source (output valid, output name_byte, output segment_start,
                  output segment_end, input ready);
  modport sink   (input valid, input name_byte, input segment_start,
                  input segment_end, output ready);
endinterface

interface nnee_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;
  logic       segment_done;
  logic       rejected;

  modport source (output valid, output out_char, output run_last,
                  output segment_done, output rejected, input ready);
  modport sink   (input valid, input out_char, input run_last,
                  input segment_done, input rejected, output ready);
endinterface

/* src/nnee_front.sv */
module nnee_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  nnee_in_if.sink         in_i,
  input  nnee_pkg::qstat_t q_stat_i,
  output logic            push_o,
  output nnee_pkg::job_t  job_o
);
  import nnee_pkg::*;

  logic        cdn_q, cdn_d;
  logic [15:0] partial_q, partial_d;
  logic [1:0]  pend_q, pend_d;
  logic        skip_q, skip_d;

  logic        cdn_e, skip_e;
  logic [15:0] partial_e;
  logic [1:0]  pend_e;
  logic        have;
  logic        reject;
  logic [15:0] code_unit;
  logic [7:0]  b;
  logic        accept;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.name_byte;

  always_comb begin
    // segment start wipes leftovers of the previous segment
    cdn_e     = in_i.segment_start ? 1'b1  : cdn_q;
    partial_e = in_i.segment_start ? '0    : partial_q;
    pend_e    = in_i.segment_start ? 2'd0  : pend_q;
    skip_e    = in_i.segment_start ? 1'b0  : skip_q;

    have      = 1'b0;
    code_unit = '0;
    partial_d = partial_e;
    pend_d    = pend_e;

    if (!skip_e) begin
      case (pend_e)
        2'd0: begin
          if (b < AsciiLimit) begin
            code_unit = {8'h00, b};
            have      = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            partial_d = {8'h00, b};
            pend_d    = 2'd1;
          end else if (b[7:4] == 4'he) begin
            partial_d = {8'h00, b};
            pend_d    = 2'd2;
          end else begin
            code_unit = {8'h00, b};
            have      = 1'b1;
          end
        end
        2'd1: begin
          if (partial_e[15:8] == 8'h00) begin
            code_unit = {5'b00000, partial_e[4:0], b[5:0]};
          end else begin
            code_unit = {partial_e[11:8], partial_e[5:0], b[5:0]};
          end
          have      = 1'b1;
          partial_d = '0;
          pend_d    = 2'd0;
        end
        default: begin
          partial_d = {partial_e[7:0], b};
          pend_d    = 2'd1;
        end
      endcase
    end

    reject = have && cdn_e && code_unit >= UnitDigitZero && code_unit <= UnitDigitThree;

    // emit a decoded unit, or the orphan lead byte of a truncated sequence
    push_o        = 1'b0;
    job_o.err     = reject;
    job_o.seg_end = in_i.segment_end;
    job_o.code_unit = code_unit;
    if (!skip_e && have) begin
      push_o = accept;
    end else if (!skip_e && in_i.segment_end && pend_d != 2'd0) begin
      push_o          = accept;
      job_o.code_unit = {8'h00, (partial_d[15:8] == 8'h00) ? partial_d[7:0] : partial_d[15:8]};
    end

    cdn_d  = cdn_e;
    skip_d = skip_e;
    if (have) begin
      if (reject) begin
        skip_d = 1'b1;
      end else begin
        cdn_d = (code_unit == UnitSlash);
      end
    end
    if (in_i.segment_end) begin
      cdn_d     = 1'b1;
      partial_d = '0;
      pend_d    = 2'd0;
      skip_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cdn_q     <= 1'b1;
      partial_q <= '0;
      pend_q    <= 2'd0;
      skip_q    <= 1'b0;
    end else if (accept) begin
      cdn_q     <= cdn_d;
      partial_q <= partial_d;
      pend_q    <= pend_d;
      skip_q    <= skip_d;
    end
  end

endmodule

/* src/nnee_fifo.sv */
module nnee_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nnee_pkg::job_t   job_i,
  input  logic             pop_i,
  output nnee_pkg::job_t   head_o,
  output nnee_pkg::qstat_t stat_o
);
  import nnee_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntMax);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/nnee_back.sv */
module nnee_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nnee_pkg::job_t   head_i,
  input  nnee_pkg::qstat_t q_stat_i,
  output logic             pop_o,
  output logic             busy_o,
  nnee_out_if.source       out_o
);
  import nnee_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [2:0] len;
  logic [6:0] ch;
  logic       last;
  logic       load;
  logic       valid_q;
  logic [6:0] char_q;
  logic       run_last_q, seg_done_q, rejected_q;
  logic [15:0] u;

  assign u = head_i.code_unit;

  always_comb begin
    if (head_i.err || is_alnum(u) || u == UnitSlash) begin
      len = LenShort;
    end else if (u == UnitUnderscore || u == UnitSemicolon || u == UnitBracket) begin
      len = LenPair;
    end else begin
      len = LenHex;
    end

    case (idx_q)
      3'd0: begin
        if (head_i.err) begin
          ch = CharNul;
        end else if (is_alnum(u)) begin
          ch = u[6:0];
        end else begin
          ch = CharUnderscore;
        end
      end
      3'd1: begin
        if (u == UnitUnderscore) begin
          ch = CharOne;
        end else if (u == UnitSemicolon) begin
          ch = CharTwo;
        end else if (u == UnitBracket) begin
          ch = CharThree;
        end else begin
          ch = CharZero;
        end
      end
      3'd2:    ch = hex_char(u[15:12]);
      3'd3:    ch = hex_char(u[11:8]);
      3'd4:    ch = hex_char(u[7:4]);
      default: ch = hex_char(u[3:0]);
    endcase

    last  = (idx_q == len - 3'd1);
    load  = !q_stat_i.empty && (!valid_q || out_o.ready);
    pop_o = load && last;
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  assign busy_o = (idx_q != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q     <= ch;
      run_last_q <= last;
      seg_done_q <= last && (head_i.seg_end || head_i.err);
      rejected_q <= head_i.err;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_char     = char_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.segment_done = seg_done_q;
  assign out_o.rejected     = rejected_q;

endmodule

/* src/native_name_escape_encoder.sv */
// Name segment escaper: modified UTF-8 bytes in, escaped ASCII characters out.
// in_i carries one byte per word with segment_start / segment_end marks.
// out_o carries one character per word; run_last closes the characters of
// one input byte, segment_done closes the segment, rejected flags the error
// word that cancels a segment starting (or continuing after '/') with 0..3.
// Throughput: one byte per cycle while each byte yields one character and
// out_o.ready stays high; an escaped unit holds the serializer for its
// length (2 or 6 characters), and the character serializer sets the rate.
// The unit queue between decoder and serializer absorbs those bursts.
// Path: a decoded unit is written into the unit queue; its characters are registered at the output.
// Reset: asynchronous, clears decoder state, queue and output valid;
// in_i.ready is high out of reset.
// Stall: when out_o.ready is low the output word holds; the decoder keeps
// taking bytes until the queue fills, then drops in_i.ready.
module native_name_escape_encoder #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nnee_in_if.sink     in_i,
  nnee_out_if.source  out_o
);
  import nnee_pkg::*;

`include "native_name_escape_encoder_assert.svh"

  job_t   push_job;
  job_t   head_job;
  qstat_t q_stat;
  logic   push;
  logic   pop;
  logic   back_busy;

  // Decode bytes to units and check the leading-digit rule.
  nnee_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Hold decoded units until the serializer is free.
  nnee_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  // Expand each unit into its escape sequence, one character per cycle while out_o.ready is high.
  nnee_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .busy_o   (back_busy),
    .out_o    (out_o)
  );

  // Mid-sequence the unit being expanded must still sit at the queue head.
  `NNEE_ASSERT(a_busy_has_head, clk_i, rst_ni, back_busy |-> !q_stat.empty, "serializer busy on empty queue")
  // A push without a pop leaves the queue nonempty.
  `NNEE_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push && !pop, !q_stat.empty, "pushed unit lost")
  // A word that closes a segment also closes its byte.
  `NNEE_ASSERT(a_done_is_last, clk_i, rst_ni, out_o.valid && out_o.segment_done |-> out_o.run_last, "segment closed mid byte")

endmodule

/* bench/native_name_escape_encoder_checker.sv */
`timescale 1ns / 100ps

module native_name_escape_encoder_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nnee_in_if   in_i,
  nnee_out_if  out_i,
  output int   mismatch_count_o,
  output int   awaiting_o
);
  import nnee_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       segment_done;
    logic       rejected;
  } char_word_t;

  char_word_t expected_chars[$];
  char_word_t step_words[$];

  logic        check_digit_q = 1'b1;
  logic [15:0] partial_q     = '0;
  logic [1:0]  pending_q     = '0;
  logic        skip_q        = 1'b0;

  int mismatches = 0;
  int awaiting   = 0;

  assign mismatch_count_o = mismatches;
  assign awaiting_o       = awaiting;

  function automatic void clear_decoder();
    check_digit_q = 1'b1;
    partial_q     = '0;
    pending_q     = '0;
    skip_q        = 1'b0;
  endfunction

  function automatic bit is_name_char(input logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h005a) ||
           (u >= 16'h0061 && u <= 16'h007a);
  endfunction

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    c = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h61 + {4'h0, n} - 8'd10);
    return c[6:0];
  endfunction

  function automatic void push_char(input logic [6:0] c);
    step_words.push_back('{ch: c, run_last: 1'b0, segment_done: 1'b0, rejected: 1'b0});
  endfunction

  // Escape one unit; a zero return means the segment is rejected.
  function automatic bit escape_unit(input logic [15:0] u);
    if (is_name_char(u)) begin
      if (check_digit_q && u >= UnitDigitZero && u <= UnitDigitThree) return 1'b0;
      check_digit_q = 1'b0;
      push_char(u[6:0]);
      return 1'b1;
    end
    check_digit_q = 1'b0;
    if (u == UnitSlash) begin
      check_digit_q = 1'b1;
      push_char(CharUnderscore);
      return 1'b1;
    end
    push_char(CharUnderscore);
    if (u == UnitUnderscore) begin
      push_char(CharOne);
    end else if (u == UnitSemicolon) begin
      push_char(CharTwo);
    end else if (u == UnitBracket) begin
      push_char(CharThree);
    end else begin
      push_char(CharZero);
      push_char(nibble_char(u[15:12]));
      push_char(nibble_char(u[11:8]));
      push_char(nibble_char(u[7:4]));
      push_char(nibble_char(u[3:0]));
    end
    return 1'b1;
  endfunction

  // Decode one accepted byte and queue the characters it must produce.
  function automatic void predict_byte(input logic [7:0] b, input logic s, input logic e);
    logic        have;
    logic [15:0] unit;
    logic [7:0]  lead;
    bit          ok;
    step_words.delete();
    if (s) clear_decoder();
    if (!skip_q) begin
      have = 1'b0;
      unit = '0;
      if (pending_q == 2'd0) begin
        if (b < AsciiLimit) begin
          unit = {8'h00, b};
          have = 1'b1;
        end else if (b >= 8'hc0 && b <= 8'hdf) begin
          partial_q = {8'h00, b};
          pending_q = 2'd1;
        end else if (b >= 8'he0 && b <= 8'hef) begin
          partial_q = {8'h00, b};
          pending_q = 2'd2;
        end else begin
          unit = {8'h00, b};
          have = 1'b1;
        end
      end else if (pending_q == 2'd1) begin
        // continuation top bits are never checked
        if (partial_q < 16'h0100) unit = {5'b0, partial_q[4:0], b[5:0]};
        else unit = {partial_q[11:8], partial_q[5:0], b[5:0]};
        have      = 1'b1;
        partial_q = '0;
        pending_q = 2'd0;
      end else begin
        partial_q = {partial_q[7:0], b};
        pending_q = 2'd1;
      end

      if (have) begin
        ok = escape_unit(unit);
        if (!ok) begin
          // error word replaces anything else from this byte
          expected_chars.push_back('{ch: CharNul, run_last: 1'b1, segment_done: 1'b1,
                                     rejected: 1'b1});
          if (e) clear_decoder();
          else skip_q = 1'b1;
          return;
        end
      end else if (e && pending_q != 2'd0) begin
        // truncated sequence: write out the lead byte alone
        lead = (partial_q < 16'h0100) ? partial_q[7:0] : partial_q[15:8];
        ok = escape_unit({8'h00, lead});
        if (!ok) step_words.delete();
      end
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].run_last = 1'b1;
      if (e) step_words[step_words.size() - 1].segment_done = 1'b1;
    end
    foreach (step_words[i]) expected_chars.push_back(step_words[i]);
    if (e) clear_decoder();
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_char();
    char_word_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected: char=%h last=%b done=%b rej=%b",
                                out_i.out_char, out_i.run_last, out_i.segment_done,
                                out_i.rejected));
      return;
    end
    want = expected_chars.pop_front();
    if (out_i.out_char !== want.ch)
      report_mismatch($sformatf("out_char %h, want %h", out_i.out_char, want.ch));
    if (out_i.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %b, want %b (char %h)", out_i.run_last,
                                want.run_last, want.ch));
    if (out_i.segment_done !== want.segment_done)
      report_mismatch($sformatf("segment_done %b, want %b (char %h)", out_i.segment_done,
                                want.segment_done, want.ch));
    if (out_i.rejected !== want.rejected)
      report_mismatch($sformatf("rejected %b, want %b (char %h)", out_i.rejected,
                                want.rejected, want.ch));
  endtask

  // Check the outgoing word first so nothing can match a same-edge prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
      expected_chars.delete();
    end else begin
      if (out_i.valid && out_i.ready) check_char();
      if (in_i.valid && in_i.ready)
        predict_byte(in_i.name_byte, in_i.segment_start, in_i.segment_end);
    end
    awaiting = expected_chars.size();
  end

endmodule

/* bench/native_name_escape_encoder_tb.sv */
`timescale 1ns / 100ps

module native_name_escape_encoder_tb;
  import nnee_pkg::*;

  // Random bytes after the directed run.
  localparam int RandomBytes = 150;
  // Cycles with no word moved on either side before the run is abandoned.
  localparam int IdleLimit   = 1000;
  // Output word count at which the receiver goes quiet, and for how long.
  localparam int HoldAt      = 30;
  localparam int HoldCycles  = 120;
  // Leave plenty of room for stray words after the last predicted character.
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       seg_start;
    logic       seg_end;
  } byte_word_t;

  logic clk_i;
  logic rst_ni;

  nnee_in_if  in_w ();
  nnee_out_if out_w ();

  int mismatches;
  int awaiting;
  int idle_cycles = 0;

  byte_word_t name_bytes[$];

  native_name_escape_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  native_name_escape_encoder_checker checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_w),
    .out_i            (out_w),
    .mismatch_count_o (mismatches),
    .awaiting_o       (awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abandon the run if the block stops moving words.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_byte(input logic [7:0] b, input logic s, input logic e);
    name_bytes.push_back('{name_byte: b, seg_start: s, seg_end: e});
  endfunction

  // Directed run: every escape class, decoding corner and rejection path.
  function automatic void build_directed();
    // plain letters and digits, '/', the three short escapes, hex escapes
    add_byte(8'h41, 1'b1, 1'b0);           // 'A'
    add_byte(8'h7a, 1'b0, 1'b0);           // 'z'
    add_byte(8'h39, 1'b0, 1'b0);           // '9' is fine anywhere
    add_byte(UnitSlash[7:0], 1'b0, 1'b0);
    add_byte(8'h34, 1'b0, 1'b0);           // '4' right after '/' passes
    add_byte(UnitUnderscore[7:0], 1'b0, 1'b0);
    add_byte(UnitSemicolon[7:0], 1'b0, 1'b0);
    add_byte(UnitBracket[7:0], 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7f, 1'b0, 1'b0);
    add_byte(8'hc3, 1'b0, 1'b0);           // two-byte sequence
    add_byte(8'ha9, 1'b0, 1'b0);
    add_byte(8'he2, 1'b0, 1'b0);           // three-byte sequence closing the segment
    add_byte(8'h82, 1'b0, 1'b0);
    add_byte(8'hac, 1'b0, 1'b1);
    // digit at segment start: error word, the rest (end byte too) is dropped
    add_byte(8'h30, 1'b1, 1'b0);
    add_byte(8'h78, 1'b0, 1'b1);
    // digit right after '/' on the closing byte
    add_byte(8'h61, 1'b1, 1'b0);
    add_byte(UnitSlash[7:0], 1'b0, 1'b0);
    add_byte(8'h33, 1'b0, 1'b1);
    // malformed leads, broken continuation, truncated sequence at the end
    add_byte(8'hff, 1'b1, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hc3, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'he1, 1'b0, 1'b1);
    // a new start drops the pending sequence silently
    add_byte(8'he2, 1'b1, 1'b0);
    add_byte(8'h62, 1'b1, 1'b1);
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h80, 8'hbf));
    return 8'($urandom_range(0, 255));
  endfunction

  // One segment of random content: mostly well formed, sometimes truncated,
  // missing its start or end mark.
  function automatic void add_segment();
    logic [7:0] seg[$];
    int         units;
    int         kind;
    bit         digit_checked;
    bit         with_start;
    bit         with_end;
    units         = $urandom_range(1, 6);
    digit_checked = 1'b1;
    for (int i = 0; i < units; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        seg.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7a))
                                           : 8'($urandom_range(8'h41, 8'h5a)));
        digit_checked = 1'b0;
      end else if (kind < 35) begin
        // rarely a forbidden digit where the check applies
        if (digit_checked && $urandom_range(0, 99) >= 20)
          seg.push_back(8'($urandom_range(8'h34, 8'h39)));
        else
          seg.push_back(8'($urandom_range(8'h30, 8'h39)));
        digit_checked = 1'b0;
      end else if (kind < 45) begin
        seg.push_back(UnitSlash[7:0]);
        digit_checked = 1'b1;
      end else begin
        digit_checked = 1'b0;
        if (kind < 55) begin
          case ($urandom_range(0, 2))
            0:       seg.push_back(UnitUnderscore[7:0]);
            1:       seg.push_back(UnitSemicolon[7:0]);
            default: seg.push_back(UnitBracket[7:0]);
          endcase
        end else if (kind < 65) begin
          seg.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 78) begin
          seg.push_back(8'($urandom_range(8'hc0, 8'hdf)));
          seg.push_back(cont_byte());
        end else if (kind < 90) begin
          seg.push_back(8'($urandom_range(8'he0, 8'hef)));
          seg.push_back(cont_byte());
          seg.push_back(cont_byte());
        end else if ($urandom_range(0, 1)) begin
          seg.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end else begin
          seg.push_back(8'($urandom_range(8'hf0, 8'hff)));
        end
      end
    end
    // cut a sequence short at the end of the segment
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      seg.push_back(8'($urandom_range(8'hc0, 8'hdf)));
    end else if (kind < 8) begin
      seg.push_back(8'($urandom_range(8'he0, 8'hef)));
    end else if (kind < 12) begin
      seg.push_back(8'($urandom_range(8'he0, 8'hef)));
      seg.push_back(cont_byte());
    end
    with_start = ($urandom_range(0, 99) >= 5);
    with_end   = ($urandom_range(0, 99) >= 8);
    foreach (seg[i])
      add_byte(seg[i], with_start && i == 0, with_end && i == seg.size() - 1);
  endfunction

  function automatic void build_random();
    int target;
    target = name_bytes.size() + RandomBytes;
    while (name_bytes.size() < target) begin
      if ($urandom_range(0, 99) < 10) begin
        // noise: any byte with any marks
        repeat ($urandom_range(1, 3))
          add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else begin
        add_segment();
      end
    end
  endfunction

  // Offer one byte after a random gap and hold it until accepted.
  task automatic send_byte(input byte_word_t w, input int idx);
    int gap;
    // two stretches run back to back with no gaps
    gap = ((idx >= 40 && idx < 90) || (idx >= 160 && idx < 190)) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_w.valid         <= 1'b1;
    in_w.name_byte     <= w.name_byte;
    in_w.segment_start <= w.seg_start;
    in_w.segment_end   <= w.seg_end;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  initial begin
    in_w.valid         = 1'b0;
    in_w.name_byte     = '0;
    in_w.segment_start = 1'b0;
    in_w.segment_end   = 1'b0;
    rst_ni             = 1'b0;
    build_directed();
    build_random();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (name_bytes[i]) send_byte(name_bytes[i], i);
    in_w.valid <= 1'b0;
    // drain: wait for every predicted character, then watch for strays
    while (awaiting != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random stalls per word, a gap-free stretch, and one long
  // hold-off that lets the unit queue fill and back up the input.
  initial begin : receiver
    int gap;
    int taken;
    out_w.ready = 1'b0;
    taken       = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = (taken >= 150 && taken < 260) ? 0 : $urandom_range(0, 9);
      if (taken == HoldAt) gap = HoldCycles;
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_w.ready <= 1'b1;
      do @(posedge clk_i); while (!out_w.valid);
      @(negedge clk_i);
      taken++;
    end
  end

endmodule

/* filelist.f */
+incdir+src
src/nnee_pkg.sv
src/nnee_if.sv
src/nnee_front.sv
src/nnee_fifo.sv
src/nnee_back.sv
src/native_name_escape_encoder.sv
bench/native_name_escape_encoder_checker.sv
bench/native_name_escape_encoder_tb.sv
